### hw/rtl/hrcp_pkg.sv
// Shared types and constants for the HTTP response chunked parser.
package hrcp_pkg;

   typedef enum logic [2:0] {
      PH_STATUS = 3'd0,
      PH_HEADER = 3'd1,
      PH_RAW    = 3'd2,
      PH_CSIZE  = 3'd3,
      PH_CDATA  = 3'd4,
      PH_CTRAIL = 3'd5,
      PH_DONE   = 3'd6,
      PH_DEAD   = 3'd7
   } phase_type;

   localparam logic [2:0] ST_PENDING  = 3'd0;
   localparam logic [2:0] ST_OK       = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_OTHER    = 3'd3;
   localparam logic [2:0] ST_BAD      = 3'd4;
   localparam logic [2:0] ST_NODIGIT  = 3'd5;

   localparam int PFX_STATUS_LEN  = 9;
   localparam int PFX_LENGTH_LEN  = 16;
   localparam int PFX_CHUNKED_LEN = 26;

   localparam logic [8*9-1:0]  PFX_STATUS  = "HTTP/1.1 ";
   localparam logic [8*16-1:0] PFX_LENGTH  = "Content-Length: ";
   localparam logic [8*26-1:0] PFX_CHUNKED = "Transfer-Encoding: chunked";

   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        headers_done;
      logic [2:0]  response_status;
      logic [9:0]  status_code;
      logic        length_valid;
      logic [63:0] content_length;
      logic        chunked_mode;
      logic        body_done;
      logic [63:0] body_bytes;
   } result_type;

   // prefix character p of string k (0 status, 1 length, 2 chunked)
   function automatic logic [7:0] pfx_char(input logic [1:0] k, input logic [4:0] p);
      logic [7:0] c;
      c = 8'h00;
      case (k)
         2'd0: if (p < 5'(PFX_STATUS_LEN))
            c = PFX_STATUS[8*(PFX_STATUS_LEN-1-int'(p)) +: 8];
         2'd1: if (p < 5'(PFX_LENGTH_LEN))
            c = PFX_LENGTH[8*(PFX_LENGTH_LEN-1-int'(p)) +: 8];
         default: if (p < 5'(PFX_CHUNKED_LEN))
            c = PFX_CHUNKED[8*(PFX_CHUNKED_LEN-1-int'(p)) +: 8];
      endcase
      return c;
   endfunction

   function automatic logic [4:0] digit_value(input logic [7:0] b);
      logic [4:0] d;
      if (b >= "0" && b <= "9") d = 5'(b - "0");
      else if (b >= "a" && b <= "f") d = 5'(b - "a" + 8'd10);
      else if (b >= "A" && b <= "F") d = 5'(b - "A" + 8'd10);
      else d = 5'd31;
      return d;
   endfunction

endpackage

### hw/rtl/http_response_chunked_parser_top.sv
// A request is parsed in the cycle it is accepted; its response is
// registered and offered in the cycle after.
// Throughput: one byte per cycle unless rsp is full and rsp_tready is low;
// rsp is a single output register that is refilled while it is being taken.
// Reset: synchronous, clears all parse state, the response valid flag and the
// ignore_content_length register.
module http_response_chunked_parser_top
   import hrcp_pkg::*;
#(
   parameter int LENGTH_WIDTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // start_response
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,   // payload_byte, status_code, content_length, body_bytes, pad
   output logic [7:0]   rsp_tuser,   // payload_valid, headers_done, response_status (3),
                                     // length_valid, chunked_mode, body_done
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   logic       ign_ff;
   logic       step;
   result_type res;
   result_type out_ff;
   logic       ov_ff;

   assign req_tready = !ov_ff || rsp_tready;
   assign step = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   hrcp_core #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_core (
      .clock(clock), .reset(reset), .step(step), .ignore_cl(ign_ff),
      .start_response(req_tuser), .data_byte(req_tdata), .result(res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ign_ff <= 1'b0;
         ov_ff  <= 1'b0;
      end else begin
         if (csr_valid) ign_ff <= csr_data;
         if (step) ov_ff <= 1'b1;
         else if (rsp_tready) ov_ff <= 1'b0;
      end
      if (step) out_ff <= res;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {6'd0, out_ff.body_bytes, out_ff.content_length,
                       out_ff.status_code, out_ff.payload_byte};
   assign rsp_tuser = {out_ff.body_done, out_ff.chunked_mode, out_ff.length_valid,
                       out_ff.response_status, out_ff.headers_done, out_ff.payload_valid};

endmodule

### hw/rtl/hrcp_core.sv
// Parse state and per-byte next-state logic of the response parser.
module hrcp_core
   import hrcp_pkg::*;
#(
   parameter int LENGTH_WIDTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       ignore_cl,
   input  logic       start_response,
   input  logic [7:0] data_byte,
   output result_type result
);

   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

   phase_type             phase_ff, phase_in;
   logic [4:0]            pos_ff, pos_in;
   logic [2:0]            match_ff, match_in;
   logic                  text_ff, text_in;
   logic [LENGTH_WIDTH-1:0] acc_ff, acc_in;
   logic                  got_ff, got_in, stop_ff, stop_in;
   logic [LENGTH_WIDTH-1:0] chunk_ff, chunk_in;
   logic [2:0]            stat_ff, stat_in;
   logic [9:0]            code_ff, code_in;
   logic                  lenv_ff, lenv_in, chk_ff, chk_in;
   logic [LENGTH_WIDTH-1:0] len_ff, len_in;
   logic [63:0]           cnt_ff, cnt_in;

   always_comb begin
      phase_type             ph;
      logic [4:0]            p;
      logic [2:0]            m;
      logic [LENGTH_WIDTH-1:0] a;
      logic                  g, s, t, valid, numok;
      logic [4:0]            d, base, start;
      logic [LENGTH_WIDTH+4:0] prod;
      logic [9:0]            code;

      code = '0; prod = '0; d = '0; base = 5'd10; start = '0; numok = 1'b0;
      ph = phase_ff; p = pos_ff; m = match_ff; t = text_ff;
      a = acc_ff; g = got_ff; s = stop_ff;
      chunk_in = chunk_ff; stat_in = stat_ff; code_in = code_ff;
      lenv_in = lenv_ff; chk_in = chk_ff; len_in = len_ff; cnt_in = cnt_ff;
      if (start_response) begin
         ph = PH_STATUS; p = '0; m = 3'b111; t = 1'b0; a = '0; g = 1'b0; s = 1'b0;
         chunk_in = '0; stat_in = ST_PENDING; code_in = '0;
         lenv_in = 1'b0; chk_in = 1'b0; len_in = '0; cnt_in = '0;
      end
      valid = 1'b0;
      phase_in = ph; pos_in = p; match_in = m; text_in = t;
      acc_in = a; got_in = g; stop_in = s;

      case (ph)
         PH_STATUS, PH_HEADER, PH_CSIZE: begin
            if (data_byte == CH_LF) begin
               if (ph == PH_CSIZE) begin
                  if (a == '0) phase_in = PH_DONE;
                  else begin
                     chunk_in = a;
                     phase_in = PH_CDATA;
                  end
               end else if (!t) begin
                  phase_in = chk_in ? PH_CSIZE : PH_RAW;
               end else if (ph == PH_STATUS) begin
                  if (!(m[0] && p >= 5'(PFX_STATUS_LEN))) begin
                     stat_in = ST_BAD;
                     phase_in = PH_HEADER;
                  end else if (!g) begin
                     stat_in = ST_NODIGIT;
                     phase_in = PH_DEAD;
                  end else begin
                     code = (a > LENGTH_WIDTH'(999)) ? 10'd999 : a[9:0];
                     code_in = code;
                     stat_in = (code == 10'd200 || code == 10'd206) ? ST_OK :
                               (code == 10'd404) ? ST_NOTFOUND : ST_OTHER;
                     phase_in = PH_HEADER;
                  end
               end else begin
                  if (m[1] && p >= 5'(PFX_LENGTH_LEN) && !ignore_cl && !lenv_in) begin
                     len_in = a;
                     lenv_in = 1'b1;
                  end else if (m[2] && p >= 5'(PFX_CHUNKED_LEN)) begin
                     chk_in = 1'b1;
                  end
               end
               pos_in = '0; match_in = 3'b111; text_in = 1'b0;
               acc_in = '0; got_in = 1'b0; stop_in = 1'b0;
            end else begin
               for (int k = 0; k < 3; k++)
                  if (p < ((k == 0) ? 5'(PFX_STATUS_LEN) : (k == 1) ? 5'(PFX_LENGTH_LEN) :
                           5'(PFX_CHUNKED_LEN)) && data_byte != pfx_char(2'(k), p))
                     match_in[k] = 1'b0;
               start = (ph == PH_STATUS) ? 5'(PFX_STATUS_LEN) :
                       (ph == PH_HEADER) ? 5'(PFX_LENGTH_LEN) : 5'd0;
               base  = (ph == PH_CSIZE) ? 5'd16 : 5'd10;
               numok = (ph == PH_CSIZE) ? 1'b1 :
                       (ph == PH_STATUS) ? match_in[0] : match_in[1];
               d = digit_value(data_byte);
               if (p >= start && numok && !s) begin
                  if (d < base) begin
                     prod = (LENGTH_WIDTH+5)'(a) * (LENGTH_WIDTH+5)'(base)
                            + (LENGTH_WIDTH+5)'(d);
                     acc_in = (prod[LENGTH_WIDTH+4:LENGTH_WIDTH] != '0) ? LEN_MAX :
                              prod[LENGTH_WIDTH-1:0];
                     got_in = 1'b1;
                  end else if (!g && (data_byte == CH_SPACE || data_byte == CH_TAB)) begin
                     acc_in = a;
                  end else begin
                     stop_in = 1'b1;
                  end
               end
               if (p < 5'd31) pos_in = p + 5'd1;
               if (data_byte != CH_CR) text_in = 1'b1;
            end
         end
         PH_RAW: valid = 1'b1;
         PH_CDATA: begin
            if (chunk_in != '0) begin
               valid = 1'b1;
               chunk_in = chunk_in - LENGTH_WIDTH'(1);
               if (chunk_in == '0) phase_in = PH_CTRAIL;
            end else if (data_byte == CH_LF) begin
               phase_in = PH_CSIZE;
               pos_in = '0; match_in = 3'b111; text_in = 1'b0;
               acc_in = '0; got_in = 1'b0; stop_in = 1'b0;
            end else begin
               phase_in = PH_CTRAIL;
            end
         end
         PH_CTRAIL: begin
            if (data_byte == CH_LF) begin
               phase_in = PH_CSIZE;
               pos_in = '0; match_in = 3'b111; text_in = 1'b0;
               acc_in = '0; got_in = 1'b0; stop_in = 1'b0;
            end
         end
         default: ;
      endcase

      if (valid && cnt_in != '1) cnt_in = cnt_in + 64'd1;

      result.payload_valid   = valid;
      result.payload_byte    = valid ? data_byte : 8'd0;
      result.headers_done    = (phase_in == PH_RAW || phase_in == PH_CSIZE ||
                                phase_in == PH_CDATA || phase_in == PH_CTRAIL ||
                                phase_in == PH_DONE);
      result.response_status = stat_in;
      result.status_code     = code_in;
      result.length_valid    = lenv_in;
      result.content_length  = lenv_in ? 64'(len_in) : 64'd0;
      result.chunked_mode    = chk_in;
      result.body_done       = (phase_in == PH_DONE);
      result.body_bytes      = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STATUS; pos_ff <= '0; match_ff <= 3'b111; text_ff <= 1'b0;
         acc_ff <= '0; got_ff <= 1'b0; stop_ff <= 1'b0; chunk_ff <= '0;
         stat_ff <= ST_PENDING; code_ff <= '0; lenv_ff <= 1'b0; chk_ff <= 1'b0;
         len_ff <= '0; cnt_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; pos_ff <= pos_in; match_ff <= match_in; text_ff <= text_in;
         acc_ff <= acc_in; got_ff <= got_in; stop_ff <= stop_in; chunk_ff <= chunk_in;
         stat_ff <= stat_in; code_ff <= code_in; lenv_ff <= lenv_in; chk_ff <= chk_in;
         len_ff <= len_in; cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE || phase_ff == PH_DEAD) |-> !result.payload_valid)
      else $error("payload after end of body");
   assert property (@(posedge clock) disable iff (reset)
      (step && result.payload_valid && !start_response && cnt_ff != '1) |=>
      cnt_ff == $past(cnt_ff) + 64'd1)
      else $error("delivered count did not advance");
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CDATA) |-> chk_ff)
      else $error("chunk data outside chunked mode");

endmodule

### tb/tb_http_response_chunked_parser_top.sv
// Self-checking testbench for the HTTP response chunked parser top level.
`timescale 1ns / 100ps

module tb_http_response_chunked_parser_top;
   import hrcp_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TARGET_BYTES   = 900;

   typedef enum logic [1:0] {
      K_BYTE  = 2'd0,
      K_CFG   = 2'd1,
      K_DRAIN = 2'd2
   } stim_kind_type;

   typedef struct {
      stim_kind_type kind;
      logic          start;
      logic [7:0]    data;
   } stim_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;
   logic [7:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_data = 1'b0;

   stim_type   request_q[$];
   result_type parsed_q[$];
   int         error_count = 0;
   int         quiet_cycles = 0;

   // parser state mirrored from the block
   phase_type   ph;
   logic [4:0]  line_pos;
   logic [2:0]  pfx_ok;
   logic        line_text;
   logic [63:0] num_acc;
   logic        num_seen;
   logic        num_stop;
   logic [63:0] chunk_left;
   logic [2:0]  lat_status;
   logic [9:0]  lat_code;
   logic        lat_len;
   logic        lat_chunked;
   logic [63:0] len_reg;
   logic [63:0] delivered;
   logic        ignore_len;

   string pfx_text[3] = '{"HTTP/1.1 ", "Content-Length: ", "Transfer-Encoding: chunked"};

   http_response_chunked_parser_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic prefix_hit(int k);
      return pfx_ok[k] && (int'(line_pos) >= pfx_text[k].len());
   endfunction

   function automatic logic [4:0] nibble_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return 5'(b - "0");
      if (b >= "a" && b <= "f") return 5'(b - "a" + 10);
      if (b >= "A" && b <= "F") return 5'(b - "A" + 10);
      return 5'd31;
   endfunction

   task automatic new_line();
      line_pos = '0;
      pfx_ok = 3'b111;
      line_text = 1'b0;
      num_acc = '0;
      num_seen = 1'b0;
      num_stop = 1'b0;
   endtask

   task automatic clear_parser();
      ph = PH_STATUS;
      new_line();
      chunk_left = '0;
      lat_status = ST_PENDING;
      lat_code = '0;
      lat_len = 1'b0;
      lat_chunked = 1'b0;
      len_reg = '0;
      delivered = '0;
   endtask

   task automatic scan_byte(logic [7:0] b, int from, int need, int base);
      logic [63:0] d;
      for (int k = 0; k < 3; k++)
         if (int'(line_pos) < pfx_text[k].len() && b != pfx_text[k][line_pos])
            pfx_ok[k] = 1'b0;
      if (int'(line_pos) >= from && (need > 2 || pfx_ok[need]) && !num_stop) begin
         d = 64'(nibble_of(b));
         if (d < base) begin
            if (num_acc > ({64{1'b1}} - d) / base) num_acc = {64{1'b1}};
            else num_acc = num_acc * base + d;
            num_seen = 1'b1;
         end else if (!num_seen && (b == CH_SPACE || b == CH_TAB)) begin
            // skip leading blanks
         end else begin
            num_stop = 1'b1;
         end
      end
      if (line_pos < 5'd31) line_pos++;
      if (b != CH_CR) line_text = 1'b1;
   endtask

   task automatic close_line();
      logic [9:0] code;
      if (ph == PH_CSIZE) begin
         if (num_acc == 0) ph = PH_DONE;
         else begin
            chunk_left = num_acc;
            ph = PH_CDATA;
         end
      end else if (!line_text) begin
         ph = lat_chunked ? PH_CSIZE : PH_RAW;
      end else if (ph == PH_STATUS) begin
         if (!prefix_hit(0)) begin
            lat_status = ST_BAD;
            ph = PH_HEADER;
         end else if (!num_seen) begin
            lat_status = ST_NODIGIT;
            ph = PH_DEAD;
         end else begin
            code = num_acc > 999 ? 10'd999 : num_acc[9:0];
            lat_code = code;
            lat_status = (code == 200 || code == 206) ? ST_OK :
                         (code == 404 ? ST_NOTFOUND : ST_OTHER);
            ph = PH_HEADER;
         end
      end else if (prefix_hit(1) && !ignore_len && !lat_len) begin
         len_reg = num_acc;
         lat_len = 1'b1;
      end else if (prefix_hit(2)) begin
         lat_chunked = 1'b1;
      end
      new_line();
   endtask

   task automatic parse_request(logic start, logic [7:0] b);
      result_type r;
      logic pay;
      pay = 1'b0;
      if (start) clear_parser();
      case (ph)
         PH_STATUS, PH_HEADER, PH_CSIZE: begin
            if (b == CH_LF) close_line();
            else if (ph == PH_STATUS) scan_byte(b, 9, 0, 10);
            else if (ph == PH_HEADER) scan_byte(b, 16, 1, 10);
            else scan_byte(b, 0, 3, 16);
         end
         PH_RAW: pay = 1'b1;
         PH_CDATA: begin
            if (chunk_left != 0) begin
               pay = 1'b1;
               chunk_left--;
               if (chunk_left == 0) ph = PH_CTRAIL;
            end else if (b == CH_LF) begin
               ph = PH_CSIZE;
               new_line();
            end else begin
               ph = PH_CTRAIL;
            end
         end
         PH_CTRAIL: if (b == CH_LF) begin
            ph = PH_CSIZE;
            new_line();
         end
         default: ;
      endcase
      if (pay && delivered != {64{1'b1}}) delivered++;
      r.payload_valid   = pay;
      r.payload_byte    = pay ? b : 8'h00;
      r.headers_done    = ph inside {PH_RAW, PH_CSIZE, PH_CDATA, PH_CTRAIL, PH_DONE};
      r.response_status = lat_status;
      r.status_code     = lat_code;
      r.length_valid    = lat_len;
      r.content_length  = lat_len ? len_reg : '0;
      r.chunked_mode    = lat_chunked;
      r.body_done       = ph == PH_DONE;
      r.body_bytes      = delivered;
      parsed_q.push_back(r);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // ---------------- stimulus building ----------------
   task automatic add_text(string s, logic first_start);
      stim_type it;
      for (int i = 0; i < s.len(); i++) begin
         it.kind = K_BYTE;
         it.start = first_start && i == 0;
         it.data = s[i];
         request_q.push_back(it);
      end
   endtask

   task automatic add_raw(int n);
      stim_type it;
      for (int i = 0; i < n; i++) begin
         it.kind = K_BYTE;
         it.start = $urandom_range(49) == 0;
         it.data = 8'($urandom);
         request_q.push_back(it);
      end
   endtask

   task automatic add_ctrl(stim_kind_type k, logic v);
      stim_type it;
      it.kind = k;
      it.start = 1'b0;
      it.data = {7'b0, v};
      request_q.push_back(it);
   endtask

   function automatic string eol();
      if ($urandom_range(5) == 0) return "\n";
      return "\r\n";
   endfunction

   function automatic string hex_size(int n);
      string s;
      s = $sformatf("%0h", n);
      if ($urandom_range(1)) s = s.toupper();
      return s;
   endfunction

   task automatic add_response();
      int r;
      int n;
      logic chunked;
      string s;
      string zs;
      chunked = 1'b0;
      r = $urandom_range(99);
      if (r < 30) s = "HTTP/1.1 200";
      else if (r < 40) s = "HTTP/1.1 206 Partial";
      else if (r < 50) s = "HTTP/1.1 404 Not Found";
      else if (r < 70) s = $sformatf("HTTP/1.1 %0d OK", $urandom_range(999, 100));
      else if (r < 76) s = $sformatf("HTTP/1.1  \t%0d", $urandom_range(99999, 1000));
      else if (r < 82) s = "HTTP/1.0 200 OK";
      else if (r < 87) s = "HTTP/1.1 OK";
      else if (r < 91) s = "";
      else s = "HTTP/1.1 9999999999999999999999";
      add_text({s, eol()}, 1'b1);
      n = $urandom_range(3);
      for (int h = 0; h < n; h++) begin
         r = $urandom_range(99);
         if (r < 35) s = $sformatf("Content-Length: %0d", $urandom_range(5000));
         else if (r < 42) s = "Content-Length: 123456789012345678901234";
         else if (r < 47) s = "Content-Length: x";
         else if (r < 75) begin
            s = "Transfer-Encoding: chunked";
            chunked = 1'b1;
         end else if (r < 85) s = "Transfer-Encoding: gzip";
         else s = "Server: x";
         add_text({s, eol()}, 1'b0);
      end
      if ($urandom_range(3) == 0) add_text("\r\r\n", 1'b0);
      else add_text("\r\n", 1'b0);
      if (chunked) begin
         n = $urandom_range(3);
         for (int c = 0; c < n; c++) begin
            r = $urandom_range(12, 1);
            add_text({" ", hex_size(r), ";x", eol()}, 1'b0);
            add_raw(r);
            add_text(eol(), 1'b0);
         end
         if ($urandom_range(1)) zs = "0";
         else zs = "g";
         add_text({zs, eol(), "\r\n"}, 1'b0);
         add_raw($urandom_range(4));
      end else begin
         add_raw($urandom_range(20));
      end
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h actual %0h", $realtime, name, want, got);
         error_count++;
      end
   endtask

   // ---------------- driver ----------------
   always @(posedge clock) begin
      logic nv;
      logic ncv;
      int gap;
      int calm;
      stim_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
         gap = 0;
         calm = 0;
      end else begin
         nv = req_tvalid;
         ncv = csr_valid;
         quiet_cycles = (parsed_q.size() == 0) ? quiet_cycles + 1 : 0;
         if (req_tvalid && req_tready) begin
            parse_request(req_tuser, req_tdata);
            nv = 1'b0;
            quiet_cycles = 0;
         end
         if (csr_valid && csr_ready) begin
            ignore_len = csr_data;
            ncv = 1'b0;
         end
         if (!nv && !ncv && request_q.size() > 0) begin
            it = request_q[0];
            if (it.kind == K_BYTE) begin
               if (gap > 0) gap--;
               else begin
                  nv = 1'b1;
                  req_tdata <= it.data;
                  req_tuser <= it.start;
                  void'(request_q.pop_front());
                  if (calm > 0) calm--;
                  else if ($urandom_range(39) == 0) calm = $urandom_range(60, 20);
                  gap = (calm > 0) ? 0 : pick_gap();
               end
            end else if (quiet_cycles >= 4) begin
               // block is idle: apply the pending control step
               if (it.kind == K_CFG) begin
                  ncv = 1'b1;
                  csr_data <= it.data[0];
               end
               void'(request_q.pop_front());
            end
         end
         req_tvalid <= nv;
         csr_valid <= ncv;
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      int stall;
      int calm;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall = 0;
         calm = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (parsed_q.size() == 0) begin
               $display("%0t: response with no request pending, expected none actual %0h",
                        $realtime, rsp_tdata);
               error_count++;
            end else begin
               want = parsed_q.pop_front();
               check_field("payload_byte", want.payload_byte, rsp_tdata[7:0]);
               check_field("status_code", want.status_code, rsp_tdata[17:8]);
               check_field("content_length", want.content_length, rsp_tdata[81:18]);
               check_field("body_bytes", want.body_bytes, rsp_tdata[145:82]);
               check_field("payload_valid", want.payload_valid, rsp_tuser[0]);
               check_field("headers_done", want.headers_done, rsp_tuser[1]);
               check_field("response_status", want.response_status, rsp_tuser[4:2]);
               check_field("length_valid", want.length_valid, rsp_tuser[5]);
               check_field("chunked_mode", want.chunked_mode, rsp_tuser[6]);
               check_field("body_done", want.body_done, rsp_tuser[7]);
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (calm > 0) calm--;
            else if ($urandom_range(49) == 0) calm = $urandom_range(80, 20);
            else stall = pick_gap();
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      int idle;
      if (reset) idle = 0;
      else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
               (csr_valid && csr_ready)) idle = 0;
      else begin
         idle++;
         if (idle >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      int total;
      ignore_len = 1'b0;
      clear_parser();
      // directed: plain, chunked, odd status lines and repeated length
      add_text("HTTP/1.1 200\r\nContent-Length: 3\r\nContent-Length: 9\r\n\r\n", 1'b1);
      add_raw(3);
      add_text("HTTP/1.1 404\r\nTransfer-Encoding: chunked\r\n\r\n2\r\n", 1'b1);
      add_text("\x00\xff\r\nA;e\r\n0123456789\r\n0\r\n\r\nz", 1'b0);
      add_text("\r\nabc", 1'b1);
      add_text("HTTP/1.1 x\nzz", 1'b1);
      add_text("XTTP/1.1 200\nContent-Length:\n\n", 1'b1);
      add_ctrl(K_CFG, 1'b1);
      add_ctrl(K_DRAIN, 1'b0);
      total = 0;
      while (total < TARGET_BYTES) begin
         if ($urandom_range(9) == 0) add_raw($urandom_range(12, 1));
         else add_response();
         if ($urandom_range(29) == 0) add_ctrl(K_CFG, 1'($urandom));
         if ($urandom_range(39) == 0) add_ctrl(K_DRAIN, 1'b0);
         total = 0;
         foreach (request_q[i]) if (request_q[i].kind == K_BYTE) total++;
      end
      add_ctrl(K_CFG, 1'b0);
      add_response();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (request_q.size() > 0 || req_tvalid || csr_valid || parsed_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && parsed_q.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
